// ===== rtl/core/ast_pkg.sv =====
// ----------------------------------------------------------------------------
// ast_pkg
// Shared types, character codes and classification helpers for the
// assembly source tokenizer.
// ----------------------------------------------------------------------------
package ast_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int LINE_BITS   = 24;
    localparam int VALUE_BITS  = 63;

    // Result queue sizing; one byte can push two results
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef logic [OFFSET_BITS-1:0] t_offset;
    typedef logic [LINE_BITS-1:0]   t_line;
    typedef logic [VALUE_BITS-1:0]  t_value;

    localparam t_value VALUE_MAX = '1;

    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_NL         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;
    localparam logic [7:0] CH_SQUOTE     = 8'h27;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_F    = 8'h46;
    localparam logic [7:0] CH_UPPER_X    = 8'h58;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_LBRACKET   = 8'h5B;
    localparam logic [7:0] CH_RBRACKET   = 8'h5D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_F    = 8'h66;
    localparam logic [7:0] CH_LOWER_X    = 8'h78;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_DOT,
        MODE_ZERO,
        MODE_DEC,
        MODE_HEX,
        MODE_STR,
        MODE_CMT
    } t_scan_mode;

    typedef enum logic [3:0] {
        TOK_IDENT    = 4'd0,
        TOK_NUMBER   = 4'd1,
        TOK_STRING   = 4'd2,
        TOK_COMMA    = 4'd3,
        TOK_COLON    = 4'd4,
        TOK_LBRACKET = 4'd5,
        TOK_RBRACKET = 4'd6,
        TOK_PLUS     = 4'd7,
        TOK_MINUS    = 4'd8,
        TOK_STAR     = 4'd9,
        TOK_DOT      = 4'd10,
        TOK_NEWLINE  = 4'd11,
        TOK_EOF      = 4'd12,
        TOK_ERROR    = 4'd13
    } t_token_kind;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_UNTERM     = 2'd1,
        ERR_UNEXPECTED = 2'd2
    } t_error_kind;

    typedef struct packed {
        t_token_kind kind;
        t_error_kind err;
        t_value      value;
        t_line       line;
        t_line       column;
        t_offset     start;
        t_offset     length;
        logic        last;
    } t_result;

    // Results produced by one byte, handed to the result queue
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z)) ||
               ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z));
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        return is_alpha(b) || is_digit(b) || (b == CH_UNDERSCORE);
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return is_digit(b) ||
               ((b >= CH_LOWER_A) && (b <= CH_LOWER_F)) ||
               ((b >= CH_UPPER_A) && (b <= CH_UPPER_F));
    endfunction

    // Nibble value of a hex digit; letters have bit 3 set after adding 9
    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [3:0] v;
        if (is_digit(b)) begin
            v = b[3:0];
        end else begin
            v = b[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

// ===== rtl/core/assembly_source_tokenizer.sv =====
// ----------------------------------------------------------------------------
// assembly_source_tokenizer
// Byte-serial tokenizer for assembly source text.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready, i_source_byte) carries one source byte per
// transaction; byte 0 ends the source. Output channel (o_valid/i_ready) carries
// one token per transaction with kind, error code, value, line, column, start
// offset and length; o_last_of_run marks the final token caused by a byte.
// Tokens needing lookahead (identifier, number, lone dot) come out with the
// first byte that cannot extend them, so one byte gives zero to two tokens.
// An accepted byte is held in the input register and classified there; its
// tokens are then written into the result queue, from which the output
// channel presents them. Throughput: one byte per cycle while the queue has
// room for a two-result push; a byte that yields two tokens takes one more
// output transaction, absorbed by a four-entry result queue that pauses input
// when fewer than two slots remain.
// When the receiver stalls, results wait in the queue and input is held off
// as it fills. Reset (synchronous, active low) empties the queue and sets
// line and column to 1 and offset to 0; byte 0 does the same to scan state.
// ----------------------------------------------------------------------------
module assembly_source_tokenizer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [7:0]                      i_source_byte,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [3:0]                      o_token_kind,
    output logic [1:0]                      o_error_kind,
    output logic [ast_pkg::VALUE_BITS-1:0]  o_number_value,
    output logic [ast_pkg::LINE_BITS-1:0]   o_line_number,
    output logic [ast_pkg::LINE_BITS-1:0]   o_column_number,
    output logic [ast_pkg::OFFSET_BITS-1:0] o_start_offset,
    output logic [ast_pkg::OFFSET_BITS-1:0] o_text_length,
    output logic                            o_last_of_run
);
    import ast_pkg::*;

    t_push   push;
    logic    room;
    t_result result;

    ast_lexer u_lexer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_source_byte (i_source_byte),
        .i_room        (room),
        .o_push        (push)
    );

    ast_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (result)
    );

    assign o_token_kind    = 4'(result.kind);
    assign o_error_kind    = 2'(result.err);
    assign o_number_value  = result.value;
    assign o_line_number   = result.line;
    assign o_column_number = result.column;
    assign o_start_offset  = result.start;
    assign o_text_length   = result.length;
    assign o_last_of_run   = result.last;

endmodule

// ===== rtl/core/ast_lexer.sv =====
// ----------------------------------------------------------------------------
// ast_lexer
// Input register, scanner state and per-byte token logic. Each registered
// byte is classified against the scan mode and yields up to two results.
// ----------------------------------------------------------------------------
module ast_lexer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_source_byte,
    input  logic          i_room,
    output ast_pkg::t_push o_push
);
    import ast_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       proc;

    t_scan_mode r_mode, n_mode;
    logic       r_qd, n_qd;
    t_value     r_acc, n_acc;
    t_offset    r_pos, n_pos;
    t_line      r_line, n_line;
    t_offset    r_ls, n_ls;
    t_offset    r_tso, n_tso;
    t_line      r_tsl, n_tsl;
    t_line      r_tsc, n_tsc;

    logic [7:0]             b;
    t_offset                col_diff;
    logic [OFFSET_BITS:0]   col_sum;
    t_line                  col;
    t_offset                tok_len;
    logic [3:0]             digit;
    logic [VALUE_BITS+3:0]  acc_prod;
    logic [VALUE_BITS+3:0]  acc_sum;
    t_value                 acc_next;
    logic                   used;
    logic                   a_vld, b_vld;
    t_result                a_res, b_res;
    logic                   punct_hit;
    t_token_kind            punct_kind;

    function automatic t_result mk(input t_token_kind k, input t_error_kind e,
                                   input t_value v, input t_line ln, input t_line cl,
                                   input t_offset st, input t_offset len);
        t_result r;
        r.kind   = k;
        r.err    = e;
        r.value  = v;
        r.line   = ln;
        r.column = cl;
        r.start  = st;
        r.length = len;
        r.last   = 1'b0;
        return r;
    endfunction

    assign proc    = r_in_valid && i_room;
    assign o_ready = !r_in_valid || proc;
    assign b       = r_in_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_source_byte;
        end
    end

    // Position of the current byte
    assign col_diff = r_pos - r_ls;
    assign col_sum  = {1'b0, col_diff} + {{OFFSET_BITS{1'b0}}, 1'b1};
    assign col      = t_line'(col_sum);
    assign tok_len  = r_pos - r_tso;

    // Accumulator step: acc*base + digit, saturated
    assign digit    = (r_mode == MODE_HEX) ? hex_val(b) : b[3:0];
    assign acc_prod = (r_mode == MODE_HEX) ? {r_acc, 4'b0000}
                    : ({1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0});
    assign acc_sum  = acc_prod + {{VALUE_BITS{1'b0}}, digit};
    assign acc_next = (acc_sum > {4'b0000, VALUE_MAX}) ? VALUE_MAX
                                                     : acc_sum[VALUE_BITS-1:0];

    always_comb begin
        punct_hit  = 1'b1;
        punct_kind = TOK_COMMA;
        case (b)
            CH_COMMA:    punct_kind = TOK_COMMA;
            CH_COLON:    punct_kind = TOK_COLON;
            CH_LBRACKET: punct_kind = TOK_LBRACKET;
            CH_RBRACKET: punct_kind = TOK_RBRACKET;
            CH_PLUS:     punct_kind = TOK_PLUS;
            CH_MINUS:    punct_kind = TOK_MINUS;
            CH_STAR:     punct_kind = TOK_STAR;
            default:     punct_hit  = 1'b0;
        endcase
    end

    // Next state and results
    always_comb begin
        n_mode = r_mode;
        n_qd   = r_qd;
        n_acc  = r_acc;
        n_pos  = r_pos;
        n_line = r_line;
        n_ls   = r_ls;
        n_tso  = r_tso;
        n_tsl  = r_tsl;
        n_tsc  = r_tsc;
        used   = 1'b0;
        a_vld  = 1'b0;
        b_vld  = 1'b0;
        a_res  = '0;
        b_res  = '0;

        // First pass: close or extend the open token
        unique case (r_mode)
            MODE_IDLE: begin
            end
            MODE_IDENT: begin
                if (is_word(b)) begin
                    used = 1'b1;
                end else begin
                    a_vld  = 1'b1;
                    a_res  = mk(TOK_IDENT, ERR_NONE, '0, r_tsl, r_tsc, r_tso, tok_len);
                    n_mode = MODE_IDLE;
                end
            end
            MODE_DOT: begin
                if (is_word(b)) begin
                    used   = 1'b1;
                    n_mode = MODE_IDENT;
                end else begin
                    a_vld  = 1'b1;
                    a_res  = mk(TOK_DOT, ERR_NONE, '0, r_tsl, r_tsc, r_tso, t_offset'(1));
                    n_mode = MODE_IDLE;
                end
            end
            MODE_ZERO: begin
                if (is_digit(b)) begin
                    used   = 1'b1;
                    n_acc  = acc_next;
                    n_mode = MODE_DEC;
                end else if (b == CH_LOWER_X || b == CH_UPPER_X) begin
                    used   = 1'b1;
                    n_mode = MODE_HEX;
                end else begin
                    a_vld  = 1'b1;
                    a_res  = mk(TOK_NUMBER, ERR_NONE, r_acc, r_tsl, r_tsc, r_tso, tok_len);
                    n_mode = MODE_IDLE;
                end
            end
            MODE_DEC: begin
                if (is_digit(b)) begin
                    used  = 1'b1;
                    n_acc = acc_next;
                end else begin
                    a_vld  = 1'b1;
                    a_res  = mk(TOK_NUMBER, ERR_NONE, r_acc, r_tsl, r_tsc, r_tso, tok_len);
                    n_mode = MODE_IDLE;
                end
            end
            MODE_HEX: begin
                if (is_hex(b)) begin
                    used  = 1'b1;
                    n_acc = acc_next;
                end else begin
                    a_vld  = 1'b1;
                    a_res  = mk(TOK_NUMBER, ERR_NONE, r_acc, r_tsl, r_tsc, r_tso, tok_len);
                    n_mode = MODE_IDLE;
                end
            end
            MODE_STR: begin
                if (b == CH_NUL || b == CH_NL) begin
                    // unterminated: report at the opening quote
                    a_vld  = 1'b1;
                    a_res  = mk(TOK_ERROR, ERR_UNTERM, '0, r_tsl, r_tsc,
                                r_tso - t_offset'(1), '0);
                    n_mode = MODE_IDLE;
                end else if (b == (r_qd ? CH_DQUOTE : CH_SQUOTE)) begin
                    used   = 1'b1;
                    a_vld  = 1'b1;
                    a_res  = mk(TOK_STRING, ERR_NONE, '0, r_tsl, r_tsc, r_tso, tok_len);
                    n_mode = MODE_IDLE;
                end else begin
                    used = 1'b1;
                end
            end
            MODE_CMT: begin
                if (b == CH_NUL || b == CH_NL) begin
                    n_mode = MODE_IDLE;
                end else begin
                    used = 1'b1;
                end
            end
        endcase

        // Second pass: byte not consumed, start from idle
        if (!used) begin
            if (b == CH_NUL) begin
                b_vld = 1'b1;
                b_res = mk(TOK_EOF, ERR_NONE, '0, r_line, col, r_pos, '0);
            end else if (b == CH_SPACE || b == CH_TAB || b == CH_CR) begin
                b_vld = 1'b0;
            end else if (b == CH_NL) begin
                b_vld = 1'b1;
                b_res = mk(TOK_NEWLINE, ERR_NONE, '0, r_line, col, r_pos, t_offset'(1));
            end else if (b == CH_SEMI) begin
                b_vld  = 1'b1;
                b_res  = mk(TOK_NEWLINE, ERR_NONE, '0, r_line, col, r_pos, t_offset'(1));
                n_mode = MODE_CMT;
            end else begin
                n_tsl = r_line;
                n_tsc = col;
                n_tso = r_pos;
                if (b == CH_SQUOTE || b == CH_DQUOTE) begin
                    n_mode = MODE_STR;
                    n_qd   = (b == CH_DQUOTE);
                    n_tso  = r_pos + t_offset'(1);
                end else if (b == CH_DOT) begin
                    n_mode = MODE_DOT;
                end else if (is_alpha(b) || b == CH_UNDERSCORE) begin
                    n_mode = MODE_IDENT;
                end else if (is_digit(b)) begin
                    n_acc  = {{(VALUE_BITS-4){1'b0}}, b[3:0]};
                    n_mode = (b == CH_ZERO) ? MODE_ZERO : MODE_DEC;
                end else if (punct_hit) begin
                    b_vld = 1'b1;
                    b_res = mk(punct_kind, ERR_NONE, '0, r_line, col, r_pos, t_offset'(1));
                end else begin
                    b_vld = 1'b1;
                    b_res = mk(TOK_ERROR, ERR_UNEXPECTED, {{(VALUE_BITS-8){1'b0}}, b},
                               r_line, col, r_pos, '0);
                end
            end
        end

        // Position tracking; end of source returns everything to reset
        if (b == CH_NUL) begin
            n_mode = MODE_IDLE;
            n_qd   = 1'b0;
            n_acc  = '0;
            n_pos  = '0;
            n_line = t_line'(1);
            n_ls   = '0;
            n_tso  = '0;
            n_tsl  = t_line'(1);
            n_tsc  = t_line'(1);
        end else begin
            n_pos = r_pos + t_offset'(1);
            if (b == CH_NL) begin
                n_line = r_line + t_line'(1);
                n_ls   = r_pos + t_offset'(1);
            end
        end
    end

    // Pack results into queue slots
    always_comb begin
        o_push.second = b_res;
        o_push.second.last = 1'b1;
        if (a_vld) begin
            o_push.first = a_res;
            o_push.first.last = !b_vld;
        end else begin
            o_push.first = b_res;
            o_push.first.last = 1'b1;
        end
        if (proc) begin
            o_push.count = {1'b0, a_vld} + {1'b0, b_vld};
        end else begin
            o_push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_qd   <= 1'b0;
            r_acc  <= '0;
            r_pos  <= '0;
            r_line <= t_line'(1);
            r_ls   <= '0;
            r_tso  <= '0;
            r_tsl  <= t_line'(1);
            r_tsc  <= t_line'(1);
        end else if (proc) begin
            r_mode <= n_mode;
            r_qd   <= n_qd;
            r_acc  <= n_acc;
            r_pos  <= n_pos;
            r_line <= n_line;
            r_ls   <= n_ls;
            r_tso  <= n_tso;
            r_tsl  <= n_tsl;
            r_tsc  <= n_tsc;
        end
    end

`ifndef SYNTHESIS
    a_two_results_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count == 2'd2) |-> (!o_push.first.last && o_push.second.last))
        else $error("two-result byte has wrong last flags");

    a_one_result_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count == 2'd1) |-> o_push.first.last)
        else $error("single result without last flag");

    a_eof_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in_byte == CH_NUL) |=>
        (r_mode == MODE_IDLE && r_pos == '0 && r_line == t_line'(1)))
        else $error("end of source did not clear scanner state");
`endif

endmodule

// ===== rtl/core/ast_result_fifo.sv =====
// ----------------------------------------------------------------------------
// ast_result_fifo
// Small result queue: takes up to two results per cycle from the lexer and
// hands one per transaction to the output channel.
// ----------------------------------------------------------------------------
module ast_result_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ast_pkg::t_push   i_push,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output ast_pkg::t_result o_result
);
    import ast_pkg::*;

    t_result                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     r_head, n_head;
    logic [FIFO_AW-1:0]     r_tail, n_tail;
    logic [FIFO_CNT_W-1:0]  r_count, n_count;
    logic                   pop;
    logic [FIFO_AW-1:0]     tail_plus1;

    assign o_valid    = (r_count != '0);
    assign o_result   = r_mem[r_head];
    assign pop        = o_valid && i_ready;
    // Room check on the registered count: high only when a full two-result push fits
    assign o_room     = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign tail_plus1 = r_tail + FIFO_AW'(1);

    always_comb begin
        n_tail  = r_tail + FIFO_AW'(i_push.count);
        n_head  = pop ? (r_head + FIFO_AW'(1)) : r_head;
        n_count = r_count + FIFO_CNT_W'(i_push.count) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_tail] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[tail_plus1] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> o_room)
        else $error("push without room");

    a_count_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count == 2'd0 && !pop) |=> (r_count == $past(r_count)))
        else $error("queue count moved without push or pop");
`endif

endmodule
